// ----- sv/offset_sort_segment_split_core_defines.svh -----
// assertion macros for the offset sort and segment split block
`ifndef OFFSET_SORT_SEGMENT_SPLIT_CORE_DEFINES_SVH
`define OFFSET_SORT_SEGMENT_SPLIT_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define OSS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// condition that holds on every clock edge outside reset
`define OSS_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

`endif

// ----- sv/oss_pkg.sv -----
// package with types and constants of the offset sort and segment split block
`timescale 1ns / 1ps
`default_nettype none

package oss_pkg;

	localparam int MAX_OFFSETS = 32;
	localparam int CNT_W       = $clog2(MAX_OFFSETS + 1);
	localparam int OFS_W       = 16;

	localparam logic [1:0] OP_ADD        = 2'd0;
	localparam logic [1:0] OP_ADD_FINISH = 2'd1;
	localparam logic [1:0] OP_FINISH     = 2'd2;
	localparam logic [1:0] OP_NONE       = 2'd3;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [OFS_W-1:0] split_offset;
	} in_t;

	typedef struct packed {
		logic [OFS_W-1:0] segment_start;
		logic [OFS_W-1:0] segment_end;
		logic             error_flag;
		logic             last_segment;
	} out_t;

	typedef struct packed {
		logic             valid;
		logic [OFS_W-1:0] value;
	} slot_t;

	typedef struct packed {
		logic             insert;
		logic             shift;
		logic             clear;
		logic [OFS_W-1:0] offset;
	} chain_ctl_t;

endpackage

`default_nettype wire

// ----- sv/oss_cell.sv -----
// one cell of the sorted insertion chain
`timescale 1ns / 1ps
`default_nettype none

module oss_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire oss_pkg::chain_ctl_t ctl,
	input  wire oss_pkg::slot_t     left,
	input  wire logic               left_gt,
	input  wire oss_pkg::slot_t     right,
	output oss_pkg::slot_t          cur,
	output logic                    gt
);

	logic             valid_q;
	logic [oss_pkg::OFS_W-1:0] value_q;
	oss_pkg::slot_t   nxt;
	logic             load;

	// empty slots count as greater, so the row stays sorted with holes at the end
	assign gt  = !valid_q || (value_q > ctl.offset);
	assign cur = '{valid: valid_q, value: value_q};

	always_comb begin
		nxt  = cur;
		load = 1'b0;
		if (ctl.shift) begin
			nxt  = right;
			load = 1'b1;
		end else if (ctl.insert && gt) begin
			nxt  = left_gt ? left : oss_pkg::slot_t'{valid: 1'b1, value: ctl.offset};
			load = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= nxt.value;
		end
	end

endmodule

`default_nettype wire

// ----- sv/oss_chain.sv -----
// row of insertion cells holding the offsets in ascending order
`timescale 1ns / 1ps
`default_nettype none

module oss_chain (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire oss_pkg::chain_ctl_t ctl,
	output oss_pkg::slot_t           head
);

	oss_pkg::slot_t slot [oss_pkg::MAX_OFFSETS];
	logic           gt   [oss_pkg::MAX_OFFSETS];

	for (genvar i = 0; i < oss_pkg::MAX_OFFSETS; i++) begin : g_cell
		oss_pkg::slot_t left_s;
		oss_pkg::slot_t right_s;
		logic           left_gt_s;

		if (i == 0) begin : g_first
			assign left_s    = '0;
			assign left_gt_s = 1'b0;
		end else begin : g_mid
			assign left_s    = slot[i-1];
			assign left_gt_s = gt[i-1];
		end

		if (i == oss_pkg::MAX_OFFSETS - 1) begin : g_last
			assign right_s = '0;
		end else begin : g_inner
			assign right_s = slot[i+1];
		end

		oss_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.left    (left_s),
			.left_gt (left_gt_s),
			.right   (right_s),
			.cur     (slot[i]),
			.gt      (gt[i])
		);
	end

	assign head = slot[0];

endmodule

`default_nettype wire

// ----- sv/offset_sort_segment_split_core.sv -----
// top level of the offset sort and segment split block
//
// usage:
//   cfg_valid/cfg_ready/cfg_data write string_length; cfg_ready is always high,
//   so a beat is never held off. write it only while busy is low.
//   a command beat (cmd.opcode, cmd.split_offset) is taken on start while busy
//   is low. add commands keep busy low, so offsets can stream in one per
//   cycle; each one is sorted into a row of cells as it lands.
//   a finish command raises busy for the check state, then the emit state,
//   which gives n+1 segment beats (n kept offsets) by shifting the cell row
//   out one slot a cycle; an error result ends busy after the check state.
//   each result beat sits on result for exactly one cycle with result_strobe
//   high, the cycle after the check or emit cycle that made it; the receiver
//   cannot stall, every beat is gone at the end of its cycle.
//   reset empties the list, clears the overflow flag and sets string_length
//   to zero. more than MAX_OFFSETS offsets set the overflow flag and the finish
//   then gives a single error beat.
`timescale 1ns / 1ps
`default_nettype none
`include "offset_sort_segment_split_core_defines.svh"

module offset_sort_segment_split_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// command channel
	input  wire logic                      start,
	input  wire oss_pkg::in_t              cmd,
	output logic                           busy,
	// result channel
	output logic                           result_strobe,
	output oss_pkg::out_t                  result,
	// configuration channel
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [oss_pkg::OFS_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EMIT
	} state_t;

	state_t                       state_q;
	logic [oss_pkg::CNT_W-1:0]    count_q;
	logic [oss_pkg::CNT_W-1:0]    remain_q;
	logic                         ovf_q;
	logic [oss_pkg::OFS_W-1:0]    max_q;
	logic [oss_pkg::OFS_W-1:0]    prev_q;
	logic [oss_pkg::OFS_W-1:0]    length_q;
	logic                         strobe_q;
	oss_pkg::out_t                result_q;

	oss_pkg::chain_ctl_t          ctl;
	oss_pkg::slot_t               head;

	logic                         accept;
	logic                         is_add;
	logic                         is_finish;
	logic                         full;
	logic                         do_insert;
	logic                         bad;

	assign cfg_ready     = 1'b1;
	assign busy          = (state_q != ST_IDLE);
	assign result_strobe = strobe_q;
	assign result        = result_q;

	// command decode; the unused opcode does nothing
	assign accept    = start && !busy;
	assign is_add    = (cmd.opcode == oss_pkg::OP_ADD) || (cmd.opcode == oss_pkg::OP_ADD_FINISH);
	assign is_finish = (cmd.opcode == oss_pkg::OP_ADD_FINISH) ||
	                   (cmd.opcode == oss_pkg::OP_FINISH);
	assign full      = (count_q == oss_pkg::CNT_W'(oss_pkg::MAX_OFFSETS));
	assign do_insert = accept && is_add && !full;

	// the largest kept offset decides the range check against the length
	assign bad = ovf_q || ((count_q != '0) && (max_q >= length_q));

	always_comb begin
		ctl        = '0;
		ctl.offset = cmd.split_offset;
		ctl.insert = do_insert;
		ctl.shift  = (state_q == ST_EMIT) && (remain_q != '0);
		ctl.clear  = (state_q == ST_CHECK) && bad;
	end

	oss_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.head   (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			length_q <= cfg_data;
		end
	end

	// sequencer: collect, check, then emit one segment a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			remain_q <= '0;
			ovf_q    <= 1'b0;
			max_q    <= '0;
			prev_q   <= '0;
			strobe_q <= 1'b0;
			result_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (do_insert) begin
						count_q <= count_q + 1'b1;
						if ((count_q == '0) || (cmd.split_offset > max_q)) begin
							max_q <= cmd.split_offset;
						end
					end
					if (accept && is_add && full) begin
						ovf_q <= 1'b1;
					end
					if (accept && is_finish) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					prev_q   <= '0;
					remain_q <= count_q;
					if (bad) begin
						// single error beat, list dropped
						strobe_q <= 1'b1;
						result_q <= '{segment_start: '0, segment_end: '0,
						              error_flag: 1'b1, last_segment: 1'b1};
						count_q  <= '0;
						ovf_q    <= 1'b0;
						max_q    <= '0;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					if (remain_q != '0) begin
						result_q <= '{segment_start: prev_q, segment_end: head.value,
						              error_flag: 1'b0, last_segment: 1'b0};
						prev_q   <= head.value;
						remain_q <= remain_q - 1'b1;
					end else begin
						// closing segment runs to the end of the string
						result_q <= '{segment_start: prev_q, segment_end: length_q,
						              error_flag: 1'b0, last_segment: 1'b1};
						count_q  <= '0;
						ovf_q    <= 1'b0;
						max_q    <= '0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	`OSS_ASSERT_ALWAYS(a_count_bound, count_q <= oss_pkg::CNT_W'(oss_pkg::MAX_OFFSETS))
	`OSS_ASSERT_IMP(a_err_is_last, result_strobe && result.error_flag, result.last_segment)
	`OSS_ASSERT_IMP(a_last_empties, result_strobe && result.last_segment,
		(count_q == '0) && !ovf_q && !busy)
	`OSS_ASSERT_IMP(a_head_matches_count, state_q == ST_IDLE, head.valid == (count_q != '0))
	`OSS_ASSERT_IMP(a_emit_has_head, (state_q == ST_EMIT) && (remain_q != '0), head.valid)

endmodule

`default_nettype wire

// ----- bench/offset_sort_segment_split_core_tb.sv -----
// self-checking testbench for the offset sort and segment split block
`timescale 1ns / 1ps
`default_nettype none

module offset_sort_segment_split_core_tb;

	// quiet time after the last owed segment beat, longer than any finish
	localparam int SETTLE_CYCLES = 48;
	localparam int CYCLE_LIMIT   = 250000;
	localparam int PHASE_ITEMS   = 36;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	oss_pkg::in_t                  cmd = '0;
	logic                          busy;
	logic                          result_strobe;
	oss_pkg::out_t                 result;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [oss_pkg::OFS_W-1:0]     cfg_data = '0;

	// commands waiting for the driver, and segment beats the block still owes us
	oss_pkg::in_t                  cmd_backlog[$];
	oss_pkg::out_t                 segment_q[$];

	// predictor state: kept offsets, their count, sticky overflow, string length
	logic [oss_pkg::OFS_W-1:0]     kept_ofs[oss_pkg::MAX_OFFSETS];
	int unsigned                   kept_count = 0;
	bit                            overflowed = 1'b0;
	logic [oss_pkg::OFS_W-1:0]     cfg_length = '0;

	// driver idling, in percent of cycles
	int unsigned                   idle_pct = 10;

	int unsigned                   beats_queued = 0;
	int unsigned                   beats_taken = 0;
	int unsigned                   cycle_count = 0;
	int unsigned                   mismatches = 0;
	int unsigned                   beats_checked = 0;
	int unsigned                   finishes = 0;
	int unsigned                   error_beats = 0;
	int unsigned                   overflow_runs = 0;
	int unsigned                   length_writes = 0;
	int unsigned                   phase_items = 0;

	offset_sort_segment_split_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.cmd           (cmd),
		.busy          (busy),
		.result_strobe (result_strobe),
		.result        (result),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// offset beat: keep it while there is room, else latch the overflow
	task automatic keep_split_offset(input logic [oss_pkg::OFS_W-1:0] ofs);
		if (kept_count < oss_pkg::MAX_OFFSETS) begin
			kept_ofs[kept_count] = ofs;
			kept_count++;
		end else begin
			overflowed = 1'b1;
		end
	endtask

	// finish: range check, then either one error beat or the sorted segments
	task automatic sort_and_emit_segments();
		logic [oss_pkg::OFS_W-1:0] srt[oss_pkg::MAX_OFFSETS];
		logic [oss_pkg::OFS_W-1:0] v;
		logic [oss_pkg::OFS_W-1:0] prev;
		int unsigned               n;
		int                        j;
		bit                        bad;
		oss_pkg::out_t             seg;
		n = kept_count;
		bad = overflowed;
		if (overflowed)
			overflow_runs++;
		for (int i = 0; i < n; i++)
			if (kept_ofs[i] >= cfg_length)
				bad = 1'b1;
		kept_count = 0;
		overflowed = 1'b0;
		finishes++;
		if (bad) begin
			seg = '{segment_start: '0, segment_end: '0, error_flag: 1'b1, last_segment: 1'b1};
			segment_q.push_back(seg);
			error_beats++;
		end else begin
			// ascending insertion sort
			for (int i = 0; i < n; i++) begin
				v = kept_ofs[i];
				j = i;
				while (j > 0 && srt[j-1] > v) begin
					srt[j] = srt[j-1];
					j--;
				end
				srt[j] = v;
			end
			prev = '0;
			for (int i = 0; i < n; i++) begin
				seg = '{segment_start: prev, segment_end: srt[i], error_flag: 1'b0,
					last_segment: 1'b0};
				segment_q.push_back(seg);
				prev = srt[i];
			end
			seg = '{segment_start: prev, segment_end: cfg_length, error_flag: 1'b0,
				last_segment: 1'b1};
			segment_q.push_back(seg);
		end
	endtask

	task automatic model_command(input oss_pkg::in_t c);
		case (c.opcode)
			oss_pkg::OP_ADD: begin
				keep_split_offset(c.split_offset);
			end
			oss_pkg::OP_ADD_FINISH: begin
				keep_split_offset(c.split_offset);
				sort_and_emit_segments();
			end
			oss_pkg::OP_FINISH: begin
				sort_and_emit_segments();
			end
			default: begin
				// unused opcode changes nothing
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// driver: holds a command beat on start until the block takes it
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				// beat taken at this edge, predict from what the block saw
				model_command(cmd);
				beats_taken++;
			end
			// slot is free unless a beat is still waiting on busy
			if (!start || !busy) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
					start <= 1'b1;
					cmd <= cmd_backlog.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: every strobed beat against the oldest expected segment
	// ------------------------------------------------------------------
	task automatic compare_field(input string fname, input logic [oss_pkg::OFS_W-1:0] want,
		input logic [oss_pkg::OFS_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_proc
		oss_pkg::out_t want;
		if (arst_n && result_strobe) begin
			if (segment_q.size() == 0) begin
				$display("%0t: unexpected result beat, expected none actual %h", $time, result);
				mismatches++;
			end else begin
				want = segment_q.pop_front();
				compare_field("segment_start", want.segment_start, result.segment_start);
				compare_field("segment_end", want.segment_end, result.segment_end);
				compare_field("error_flag", oss_pkg::OFS_W'(want.error_flag),
					oss_pkg::OFS_W'(result.error_flag));
				compare_field("last_segment", oss_pkg::OFS_W'(want.last_segment),
					oss_pkg::OFS_W'(result.last_segment));
				beats_checked++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d segment beats still owed",
				cycle_count, segment_q.size());
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_cmd(input logic [1:0] op, input logic [oss_pkg::OFS_W-1:0] ofs);
		oss_pkg::in_t c;
		c.opcode = op;
		c.split_offset = ofs;
		cmd_backlog.push_back(c);
		beats_queued++;
		if (op != oss_pkg::OP_NONE)
			phase_items++;
	endtask

	// everything handed to the driver taken, every segment seen, block quiet
	task automatic settle();
		do @(posedge clk); while (beats_taken != beats_queued);
		while (segment_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// string length write, only called with the block idle
	task automatic write_length(input logic [oss_pkg::OFS_W-1:0] len);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= len;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_length = len;
		length_writes++;
	endtask

	// offset below the length where there is one
	function automatic logic [oss_pkg::OFS_W-1:0] legal_offset(
		input logic [oss_pkg::OFS_W-1:0] len);
		if (len == 0)
			return oss_pkg::OFS_W'($urandom_range(65535));
		return oss_pkg::OFS_W'($urandom_range(len - 1));
	endfunction

	// one list: n adds with random content, then a finish of the given kind
	task automatic queue_run(input logic [oss_pkg::OFS_W-1:0] len, input int unsigned n_adds,
		input logic [1:0] end_op);
		logic [oss_pkg::OFS_W-1:0] ofs;
		logic [oss_pkg::OFS_W-1:0] last_ofs;
		last_ofs = legal_offset(len);
		for (int i = 0; i <= n_adds; i++) begin
			if ($urandom_range(99) < 4)
				push_cmd(oss_pkg::OP_NONE, oss_pkg::OFS_W'($urandom));
			if ($urandom_range(99) < 15)
				ofs = last_ofs;                                    // duplicate, empty segment
			else if ($urandom_range(99) < 3)
				ofs = oss_pkg::OFS_W'($urandom_range(65535, len)); // out of range
			else
				ofs = legal_offset(len);
			if (i < n_adds)
				push_cmd(oss_pkg::OP_ADD, ofs);
			else
				push_cmd(end_op, ofs);
			last_ofs = ofs;
		end
	endtask

	task automatic random_run(input logic [oss_pkg::OFS_W-1:0] len);
		int unsigned r;
		int unsigned n;
		r = $urandom_range(99);
		if (r < 55)
			n = $urandom_range(4);
		else if (r < 80)
			n = $urandom_range(12, 5);
		else if (r < 91)
			n = $urandom_range(31, 13);
		else if (r < 95)
			n = oss_pkg::MAX_OFFSETS;
		else
			n = $urandom_range(oss_pkg::MAX_OFFSETS + 3, oss_pkg::MAX_OFFSETS + 1);
		queue_run(len, n, $urandom_range(1) ? oss_pkg::OP_ADD_FINISH : oss_pkg::OP_FINISH);
	endtask

	// mostly well-formed lists, some loose commands of any opcode between them
	task automatic random_phase(input logic [oss_pkg::OFS_W-1:0] len);
		phase_items = 0;
		while (phase_items < PHASE_ITEMS) begin
			if ($urandom_range(99) < 8)
				push_cmd(2'($urandom_range(3)), oss_pkg::OFS_W'($urandom));
			else
				random_run(len);
		end
		// close any list the loose commands left open
		push_cmd(oss_pkg::OP_FINISH, '0);
		settle();
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// length is zero out of reset: empty list gives segment 0..0
		push_cmd(oss_pkg::OP_FINISH, 16'hffff);
		settle();

		write_length(16'hffff);
		// extremes, a duplicate, an ignored opcode in the middle of a list
		push_cmd(oss_pkg::OP_ADD, 16'h0000);
		push_cmd(oss_pkg::OP_ADD, 16'hfffe);
		push_cmd(oss_pkg::OP_NONE, 16'hffff);
		push_cmd(oss_pkg::OP_ADD, 16'hfffe);
		push_cmd(oss_pkg::OP_ADD, 16'h5555);
		push_cmd(oss_pkg::OP_ADD_FINISH, 16'haaaa);
		// empty list gives the whole string
		push_cmd(oss_pkg::OP_FINISH, 16'h1234);
		// offset equal to the length is out of range
		push_cmd(oss_pkg::OP_ADD, 16'hffff);
		push_cmd(oss_pkg::OP_ADD, 16'h0007);
		push_cmd(oss_pkg::OP_FINISH, 16'h0000);
		push_cmd(oss_pkg::OP_ADD_FINISH, 16'hffff);
		push_cmd(oss_pkg::OP_ADD_FINISH, 16'h0000);
		settle();

		write_length(16'h0001);
		push_cmd(oss_pkg::OP_ADD_FINISH, 16'h0000);
		push_cmd(oss_pkg::OP_ADD, 16'h0001);
		push_cmd(oss_pkg::OP_FINISH, 16'h0000);
		push_cmd(oss_pkg::OP_ADD, 16'h0000);
		push_cmd(oss_pkg::OP_ADD_FINISH, 16'h0000);
		settle();

		// random part, one length per phase
		write_length(16'hffff);
		queue_run(16'hffff, oss_pkg::MAX_OFFSETS, oss_pkg::OP_FINISH);      // exactly full
		queue_run(16'hffff, oss_pkg::MAX_OFFSETS, oss_pkg::OP_ADD_FINISH);  // one past full
		queue_run(16'hffff, oss_pkg::MAX_OFFSETS + 3, oss_pkg::OP_FINISH);
		random_phase(16'hffff);

		write_length(16'h0001);
		random_phase(16'h0001);

		write_length(16'h0000);
		random_phase(16'h0000);

		write_length(16'd300);
		random_phase(16'd300);

		// long stretch with no idling at all
		idle_pct = 0;
		write_length(16'hffff);
		random_phase(16'hffff);
		idle_pct = 10;

		write_length(oss_pkg::OFS_W'($urandom_range(65534, 2)));
		random_phase(cfg_length);

		write_length(16'd16);
		random_phase(16'd16);

		$display("run covered %0d command beats, %0d finishes, %0d length settings",
			beats_taken, finishes, length_writes);
		$display("checked %0d result beats, %0d of them errors, %0d overflowed lists",
			beats_checked, error_beats, overflow_runs);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+sv
sv/oss_pkg.sv
sv/oss_cell.sv
sv/oss_chain.sv
sv/offset_sort_segment_split_core.sv
bench/offset_sort_segment_split_core_tb.sv
